>>> src/mwpo_pkg.sv
package mwpo_pkg;

	// Default sizes of the datapath
	localparam int PHASE_BITS_DEF      = 32;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 16;

	// Configuration port
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;
	localparam int WF_BITS   = 3;
	localparam int INC_BITS  = 32;
	localparam int GAIN_BITS = 24;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_WAVEFORM  = 2'd0;
	localparam reg_idx_t REG_PHASE_INC = 2'd1;
	localparam reg_idx_t REG_GAIN      = 2'd2;

	typedef logic [WF_BITS-1:0] wf_t;
	localparam wf_t WF_SINE   = 3'd0;
	localparam wf_t WF_SQUARE = 3'd1;
	localparam wf_t WF_TRI    = 3'd2;
	localparam wf_t WF_RISE   = 3'd3;
	localparam wf_t WF_FALL   = 3'd4;

	localparam logic [INC_BITS-1:0]  PHASE_INC_RESET = 32'd89478485;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET      = 24'd16462;

	// pi/2 in Q30
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		wf_t                  waveform;
		logic [INC_BITS-1:0]  phase_increment;
		logic [GAIN_BITS-1:0] gain;
	} cfg_t;

	// Integer Taylor series of sin(x), x and result in Q30, 0 <= x <= pi/2.
	// Elaboration only.
	function automatic logic [63:0] sin_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		x2   = (x * x) >> 30;
		term = ((x * x2) >> 30) / 64'd6;
		neg  = term;
		pos  = x;
		term = ((term * x2) >> 30) / 64'd20;
		pos  = pos + term;
		term = ((term * x2) >> 30) / 64'd42;
		neg  = neg + term;
		term = ((term * x2) >> 30) / 64'd72;
		pos  = pos + term;
		term = ((term * x2) >> 30) / 64'd110;
		neg  = neg + term;
		term = ((term * x2) >> 30) / 64'd156;
		pos  = pos + term;
		term = ((term * x2) >> 30) / 64'd210;
		neg  = neg + term;
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

	// Quarter-wave table entry i, 2^frac scale
	function automatic logic [63:0] sine_entry(input int i, input int tbits, input int frac);
		logic [63:0] x;
		logic [63:0] s;
		x = (HALF_PI_Q30 * (64'(2 * i) + 64'd1)) >> (tbits + 1);
		s = sin_q30(x);
		return ((s << frac) + (64'd1 << 29)) >> 30;
	endfunction

endpackage

>>> src/mwpo_tick_if.sv
interface mwpo_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source(output valid, output tick, input ready);
	modport sink(input valid, input tick, output ready);
endinterface

>>> src/mwpo_sample_if.sv
interface mwpo_sample_if #(
	parameter int SAMPLE_BITS = mwpo_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

>>> src/mwpo_regs.sv
module mwpo_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mwpo_pkg::ADDR_BITS-1:0] paddr,
	input  logic [mwpo_pkg::DATA_BITS-1:0] pwdata,
	output logic [mwpo_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	output mwpo_pkg::cfg_t                 cfg
);
	import mwpo_pkg::*;

	wf_t                  waveform_q;
	logic [INC_BITS-1:0]  phase_inc_q;
	logic [GAIN_BITS-1:0] gain_q;
	reg_idx_t             idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_BITS-1:2];
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waveform_q  <= WF_SINE;
			phase_inc_q <= PHASE_INC_RESET;
			gain_q      <= GAIN_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_WAVEFORM: begin
					// codes above falling saw are dropped
					if (pwdata[WF_BITS-1:0] <= WF_FALL) waveform_q <= pwdata[WF_BITS-1:0];
				end
				REG_PHASE_INC: phase_inc_q <= pwdata[INC_BITS-1:0];
				REG_GAIN:      gain_q      <= pwdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WAVEFORM:  prdata = {{(DATA_BITS-WF_BITS){1'b0}}, waveform_q};
			REG_PHASE_INC: prdata = phase_inc_q;
			REG_GAIN:      prdata = {{(DATA_BITS-GAIN_BITS){1'b0}}, gain_q};
			default:       prdata = '0;
		endcase
	end

	assign cfg.waveform        = waveform_q;
	assign cfg.phase_increment = phase_inc_q;
	assign cfg.gain            = gain_q;

endmodule

>>> src/mwpo_wave.sv
module mwpo_wave #(
	parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mwpo_pkg::cfg_t              cfg,
	mwpo_tick_if.sink                   tick_ch,
	output logic                        w_valid,
	input  logic                        w_ready,
	output logic signed [SAMPLE_BITS:0] w
);
	import mwpo_pkg::*;

	localparam int FRAC      = SAMPLE_BITS - 1;
	localparam int TW        = FRAC + 2;
	localparam int TABLE_LEN = 1 << SINE_TABLE_BITS;
	localparam int WW        = SAMPLE_BITS + 2;

	typedef logic [SAMPLE_BITS-1:0] rom_t [TABLE_LEN];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i < TABLE_LEN; i++) begin
			r[i] = SAMPLE_BITS'(sine_entry(i, SINE_TABLE_BITS, FRAC));
		end
		return r;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic [PHASE_BITS-1:0]      phase_q;
	logic [PHASE_BITS-1:0]      inc;
	logic [TW-1:0]              t;
	logic [SINE_TABLE_BITS-1:0] idx;
	logic                       accept;
	logic                       s1_en;
	logic                       s2_en;

	logic                       valid_s1;
	wf_t                        wf_s1;
	logic [TW-1:0]              t_s1;
	logic                       neg_s1;
	logic [SAMPLE_BITS-1:0]     rom_s1;

	logic                       valid_s2;
	logic signed [SAMPLE_BITS:0] w_s2;
	logic signed [WW-1:0]       tt;
	logic signed [WW-1:0]       q;
	logic signed [WW-1:0]       saw;
	logic signed [WW-1:0]       wv;

	generate
		if (PHASE_BITS > INC_BITS) begin : g_inc_wide
			assign inc = {{(PHASE_BITS-INC_BITS){1'b0}}, cfg.phase_increment};
		end else if (PHASE_BITS == INC_BITS) begin : g_inc_same
			assign inc = cfg.phase_increment;
		end else begin : g_inc_narrow
			assign inc = cfg.phase_increment[PHASE_BITS-1:0];
		end
		if (PHASE_BITS >= TW) begin : g_t_trunc
			assign t = phase_q[PHASE_BITS-1 -: TW];
		end else begin : g_t_pad
			assign t = {phase_q, {(TW-PHASE_BITS){1'b0}}};
		end
	endgenerate

	// odd quadrants read the table mirrored
	assign idx = phase_q[PHASE_BITS-2] ? ~phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS]
	                                   : phase_q[PHASE_BITS-3 -: SINE_TABLE_BITS];

	assign s2_en         = !valid_s2 || w_ready;
	assign s1_en         = !valid_s1 || s2_en;
	assign tick_ch.ready = s1_en;
	assign accept        = tick_ch.valid && s1_en && tick_ch.tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (accept) begin
			phase_q <= phase_q + inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_en) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			wf_s1  <= cfg.waveform;
			t_s1   <= t;
			neg_s1 <= phase_q[PHASE_BITS-1];
			rom_s1 <= SINE_ROM[idx];
		end
	end

	assign q   = WW'(1) <<< FRAC;
	assign tt  = WW'(t_s1);
	// (t + half turn) mod full turn, halved
	assign saw = WW'({~t_s1[TW-1], t_s1[TW-2:0]} >> 1) - q;

	always_comb begin
		unique case (wf_s1)
			WF_SINE:   wv = neg_s1 ? -WW'(rom_s1) : WW'(rom_s1);
			WF_SQUARE: wv = t_s1[TW-1] ? -q : q;
			WF_TRI: begin
				if (tt < q)              wv = tt;
				else if (tt < 3 * q)     wv = (q <<< 1) - tt;
				else                     wv = tt - (q <<< 2);
			end
			WF_RISE:   wv = saw;
			WF_FALL:   wv = -saw;
			default:   wv = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en) w_s2 <= wv[SAMPLE_BITS:0];
	end

	assign w_valid = valid_s2;
	assign w       = w_s2;

	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q))
		else $error("phase moved without an accepted tick");

	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted tick did not reach stage 1");

	a_s2_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !w_ready |=> valid_s2 && $stable(w_s2))
		else $error("stage 2 lost a stalled value");

endmodule

>>> src/mwpo_scale.sv
module mwpo_scale #(
	parameter int SAMPLE_BITS = mwpo_pkg::SAMPLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mwpo_pkg::GAIN_BITS-1:0] gain,
	input  logic                        w_valid,
	output logic                        w_ready,
	input  logic signed [SAMPLE_BITS:0] w,
	mwpo_sample_if.source               sample_ch
);
	import mwpo_pkg::*;

	localparam int PW   = SAMPLE_BITS + 1 + GAIN_BITS + 1;
	localparam int RW   = PW + 1;
	localparam int VW   = RW - 16;
	localparam int FRAC = SAMPLE_BITS - 1;

	logic                          valid_s3;
	logic signed [PW-1:0]          prod_s3;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          s3_en;
	logic                          out_en;
	logic signed [RW-1:0]          biased;
	logic signed [VW-1:0]          v;
	logic signed [VW-1:0]          hi;
	logic signed [VW-1:0]          lo;
	logic signed [SAMPLE_BITS-1:0] sat;

	assign out_en  = !out_valid_q || sample_ch.ready;
	assign s3_en   = !valid_s3 || out_en;
	assign w_ready = s3_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s3_en)  valid_s3    <= w_valid;
			if (out_en) out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_en) prod_s3 <= PW'(w) * PW'(signed'({1'b0, gain}));
	end

	// round half up, then clamp to the signed sample range
	assign biased = RW'(prod_s3) + (RW'(1) <<< 15);
	assign v      = VW'(biased >>> 16);
	assign hi     = (VW'(1) <<< FRAC) - VW'(1);
	assign lo     = -(VW'(1) <<< FRAC);

	always_comb begin
		priority if (v > hi) sat = hi[SAMPLE_BITS-1:0];
		else if (v < lo)     sat = lo[SAMPLE_BITS-1:0];
		else                 sat = v[SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (out_en) sample_q <= sat;
	end

	assign sample_ch.valid  = out_valid_q;
	assign sample_ch.sample = sample_q;

endmodule

>>> src/multi_waveform_phase_oscillator.sv
// Direct digital synthesis audio oscillator. Every tick request on tick_ch
// with tick set produces one signed sample on sample_ch and advances the
// phase accumulator by phase_increment, wrapping at a full turn; a request
// with tick clear is taken and dropped. Waveforms: sine from a quarter-wave
// ROM, square, triangle, rising and falling saw (saws run a half turn
// ahead). The unit wave is scaled by the Q8.16 gain, rounded half up and
// saturated. Throughput is one request per clock while sample_ch is not
// stalled; a sample passes four registers after its tick is taken: ROM read
// (loaded at the edge that takes the tick), wave shaping, gain multiply,
// round/saturate output register. Stages hold independently, so bubbles
// are squeezed out while sample_ch is stalled. Registers sit on the APB
// port at 0x0 waveform, 0x4 phase_increment, 0x8 gain; write them only
// while no sample is in flight. Waveform codes above 4 are ignored.
module multi_waveform_phase_oscillator #(
	parameter int PHASE_BITS      = mwpo_pkg::PHASE_BITS_DEF,
	parameter int SINE_TABLE_BITS = mwpo_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = mwpo_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mwpo_pkg::ADDR_BITS-1:0] paddr,
	input  logic [mwpo_pkg::DATA_BITS-1:0] pwdata,
	output logic [mwpo_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready,
	mwpo_tick_if.sink                      tick_ch,
	mwpo_sample_if.source                  sample_ch
);
	import mwpo_pkg::*;

	cfg_t                        cfg;
	logic                        w_valid;
	logic                        w_ready;
	logic signed [SAMPLE_BITS:0] w;

	// configuration registers
	mwpo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// phase accumulator, sine ROM and wave shaping (stages 1 and 2)
	mwpo_wave #(
		.PHASE_BITS      (PHASE_BITS),
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_wave (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.tick_ch (tick_ch),
		.w_valid (w_valid),
		.w_ready (w_ready),
		.w       (w)
	);

	// gain multiply, rounding and saturation (stage 3 and output register)
	mwpo_scale #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.gain      (cfg.gain),
		.w_valid   (w_valid),
		.w_ready   (w_ready),
		.w         (w),
		.sample_ch (sample_ch)
	);

endmodule
